@@ sv/horizontal_box_blur_rgb_defines.svh @@
// Assertion macros for the horizontal box blur block.
// Included by the modules that check their own logic; no other dependencies.
`ifndef HORIZONTAL_BOX_BLUR_RGB_DEFINES_SVH
`define HORIZONTAL_BOX_BLUR_RGB_DEFINES_SVH

`ifndef ASSERT_OFF
// Check prop on every clock edge outside reset.
`define HBB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// Check prop on every clock edge, reset included.
`define HBB_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define HBB_ASSERT(lbl, clk, rst_n, prop, msg)
`define HBB_ASSERT_ALL(lbl, clk, prop, msg)
`endif

`endif

@@ sv/hbb_pkg.sv @@
// Shared types and constants for the horizontal box blur block.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package hbb_pkg;

    localparam int MAX_ROW_WIDTH = 4096;
    localparam int CFG_W         = 13;
    localparam int COL_W         = $clog2(MAX_ROW_WIDTH);
    localparam int CH_W          = 8;
    localparam int NUM_CH        = 3;
    localparam int NUM_SLOTS     = 3;
    localparam int SUM_W         = CH_W + 2;

    // x / 3 == (x * 683) >> 11 for every x up to 3 * 255
    localparam int DIV3_MUL      = 683;
    localparam int DIV3_SH       = 11;
    localparam int PROD_W        = 2 * SUM_W;

    localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = CFG_W'(640);

    // result slots of one input word, emitted lowest first
    localparam int SLOT_AVG3 = 0;
    localparam int SLOT_AVG2 = 1;
    localparam int SLOT_CUR  = 2;

    // channel order inside a pixel
    localparam int CH_BLUE  = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_RED   = 2;

    typedef logic [NUM_CH-1:0][CH_W-1:0] pixel_t;

    typedef struct packed {
        logic [CH_W-1:0] red_in;
        logic [CH_W-1:0] green_in;
        logic [CH_W-1:0] blue_in;
        logic            last_pixel;
    } in_word_t;

    typedef struct packed {
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
        logic            last_of_run;
    } out_word_t;

    // results caused by one input word, handed to the output stage
    typedef struct packed {
        logic [NUM_SLOTS-1:0] mask;
        logic                 avg3_last;
        pixel_t [NUM_SLOTS-1:0] px;
    } burst_t;

endpackage

@@ sv/hbb_lane.sv @@
// One color channel of the blur: three-tap and two-tap truncated averages.
// Depends on hbb_pkg.
`timescale 1ns / 1ps

module hbb_lane
    import hbb_pkg::*;
(
    input  logic [CH_W-1:0] older_px,
    input  logic [CH_W-1:0] newer_px,
    input  logic [CH_W-1:0] cur_px,
    output logic [CH_W-1:0] avg3,
    output logic [CH_W-1:0] avg2
);

    logic [SUM_W-1:0]  sum3;
    logic [SUM_W-1:0]  sum2;
    logic [PROD_W-1:0] prod;

    always_comb begin
        sum3 = SUM_W'(older_px) + SUM_W'(newer_px) + SUM_W'(cur_px);
        sum2 = SUM_W'(newer_px) + SUM_W'(cur_px);
        // divide by three through the reciprocal
        prod = PROD_W'(sum3) * PROD_W'(DIV3_MUL);
        avg3 = prod[DIV3_SH +: CH_W];
        avg2 = sum2[1 +: CH_W];
    end

endmodule

@@ sv/hbb_emit.sv @@
// Output stage: merges lane results into result words and sends them one a cycle while the receiver is ready.
// Depends on hbb_pkg and horizontal_box_blur_rgb_defines.svh.
`timescale 1ns / 1ps
`include "horizontal_box_blur_rgb_defines.svh"

module hbb_emit
    import hbb_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      load,
    input  burst_t    burst,
    output logic      load_ok,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    logic [NUM_SLOTS-1:0]   mask_reg, mask_next;
    logic                   avg3_last_reg;
    pixel_t [NUM_SLOTS-1:0] px_reg;
    logic [NUM_SLOTS-1:0]   lowest;
    logic [NUM_SLOTS-1:0]   remain;
    pixel_t                 sel_px;
    logic                   sel_last;

    always_comb begin
        // pick the lowest pending slot
        lowest = mask_reg & (~mask_reg + NUM_SLOTS'(1));
        sel_px = '0;
        sel_last = 1'b0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (lowest[i]) begin
                sel_px = px_reg[i];
            end
        end
        if (lowest[SLOT_AVG3]) begin
            sel_last = avg3_last_reg;
        end else if (lowest[SLOT_CUR]) begin
            sel_last = 1'b1;
        end

        m_valid = |mask_reg;
        m_data.red_out     = sel_px[CH_RED];
        m_data.green_out   = sel_px[CH_GREEN];
        m_data.blue_out    = sel_px[CH_BLUE];
        m_data.last_of_run = sel_last;

        remain  = (m_valid && m_ready) ? (mask_reg & ~lowest) : mask_reg;
        load_ok = (remain == '0);
        mask_next = load ? burst.mask : remain;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            px_reg        <= burst.px;
            avg3_last_reg <= burst.avg3_last;
        end
    end

    `HBB_ASSERT(a_load_only_when_drained, aclk, aresetn, load |-> load_ok, "load over pending words")
    `HBB_ASSERT(a_final_word_flagged, aclk, aresetn, (m_valid && m_ready && $onehot(mask_reg)) |-> m_data.last_of_run, "last word of a burst lacks last_of_run")
    `HBB_ASSERT(a_stall_keeps_word, aclk, aresetn, (m_valid && !m_ready && !load_ok) |=> (m_valid && $stable(mask_reg)), "pending word lost under stall")

endmodule

@@ sv/horizontal_box_blur_rgb.sv @@
// Three-tap horizontal box blur over an RGB raster pixel stream.
//
// Input words arrive on s_valid/s_ready/s_data, results leave on
// m_valid/m_ready/m_data; a word moves when valid and ready are both high.
// cfg_wr_en writes cfg_wr_data into the row width (reset 640) on the same
// edge; a width of 0 acts as 1 and anything above 4096 as 4096.
// Each pixel becomes the truncated per-channel average of itself and the
// next two pixels of its row; the second-last pixel of a row averages two,
// the last passes unchanged. last_pixel ends the row early.
// A pixel's result is formed when the word that completes it is taken and
// is registered in the output stage. The first two pixels of a row give
// no result, mid-row words give one, a row-ending word gives up to three.
// Words are taken one per cycle mid-row while the receiver is ready; a row
// end holds s_ready low while the output register drains the extra words
// one a cycle as the receiver takes them. A stalled receiver holds m_data
// and stops intake once the output register cannot be emptied. Reset
// clears the held pixels, the column count and the pending results.
// Depends on hbb_pkg, hbb_lane, hbb_emit and the defines header.
`timescale 1ns / 1ps
`include "horizontal_box_blur_rgb_defines.svh"

module horizontal_box_blur_rgb
    import hbb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_word_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_word_t        m_data
);

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] width_eff;
    logic [COL_W-1:0] last_col;
    logic [COL_W-1:0] col_reg, col_next;
    pixel_t           older_reg, older_next;
    pixel_t           newer_reg, newer_next;
    pixel_t           cur_px;
    pixel_t           avg3_px;
    pixel_t           avg2_px;
    logic             accept;
    logic             row_end;
    logic             load_ok;
    burst_t           burst;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= ROW_WIDTH_RESET;
        end else if (cfg_wr_en) begin
            width_reg <= cfg_wr_data;
        end
    end

    always_comb begin
        width_eff = width_reg;
        if (width_reg == '0) begin
            width_eff = CFG_W'(1);
        end else if (width_reg > CFG_W'(MAX_ROW_WIDTH)) begin
            width_eff = CFG_W'(MAX_ROW_WIDTH);
        end
        last_col = COL_W'(width_eff - CFG_W'(1));
    end

    assign cur_px[CH_RED]   = s_data.red_in;
    assign cur_px[CH_GREEN] = s_data.green_in;
    assign cur_px[CH_BLUE]  = s_data.blue_in;

    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        hbb_lane u_lane (
            .older_px (older_reg[c]),
            .newer_px (newer_reg[c]),
            .cur_px   (cur_px[c]),
            .avg3     (avg3_px[c]),
            .avg2     (avg2_px[c])
        );
    end

    assign s_ready = load_ok;
    assign accept  = s_valid && s_ready;

    always_comb begin
        row_end = (col_reg >= last_col) || s_data.last_pixel;

        burst.px[SLOT_AVG3] = avg3_px;
        burst.px[SLOT_AVG2] = avg2_px;
        burst.px[SLOT_CUR]  = cur_px;
        burst.avg3_last     = !row_end;
        burst.mask          = '0;
        burst.mask[SLOT_AVG3] = (col_reg >= COL_W'(2));
        burst.mask[SLOT_AVG2] = row_end && (col_reg >= COL_W'(1));
        burst.mask[SLOT_CUR]  = row_end;

        col_next   = col_reg;
        older_next = older_reg;
        newer_next = newer_reg;
        if (accept) begin
            if (row_end) begin
                // restart the row
                col_next   = '0;
                older_next = '0;
                newer_next = '0;
            end else begin
                col_next   = col_reg + COL_W'(1);
                older_next = newer_reg;
                newer_next = cur_px;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            older_reg <= '0;
            newer_reg <= '0;
        end else begin
            col_reg   <= col_next;
            older_reg <= older_next;
            newer_reg <= newer_next;
        end
    end

    hbb_emit u_emit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (accept),
        .burst   (burst),
        .load_ok (load_ok),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    `HBB_ASSERT(a_row_restart, aclk, aresetn, (accept && row_end) |=> (col_reg == '0 && older_reg == '0 && newer_reg == '0), "row end did not restart the row")
    `HBB_ASSERT(a_mid_row_advance, aclk, aresetn, (accept && !row_end) |=> (col_reg == $past(col_reg) + COL_W'(1) && newer_reg == $past(cur_px)), "mid-row word did not advance")
    `HBB_ASSERT_ALL(a_reset_clears, aclk, !aresetn |=> (col_reg == '0 && !m_valid), "reset left state behind")

endmodule

@@ sim/hbb_blur_checker.sv @@
// Checker for the horizontal box blur: predicts the blurred pixel words from the
// accepted input words and the row width writes, and compares the result channel.
// Depends on hbb_pkg for the word types and channel positions.
`timescale 1ns / 1ps

module hbb_blur_checker
    import hbb_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  in_word_t         s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  out_word_t        m_data,
    output int               mismatch_count,
    output int               pending_count
);

    logic [CFG_W-1:0] row_width_q;
    pixel_t           older_px;
    pixel_t           newer_px;
    int               column;
    out_word_t        blurred_q[$];
    out_word_t        want;

    function automatic pixel_t mean_px(pixel_t a, pixel_t b, pixel_t c, int n);
        pixel_t r;
        int     sum;
        int     ch;
        for (ch = 0; ch < NUM_CH; ch++) begin
            sum = int'(a[ch]) + int'(b[ch]);
            if (n == 3) begin
                sum += int'(c[ch]);
            end
            r[ch] = CH_W'(sum / n);
        end
        return r;
    endfunction

    function automatic out_word_t to_word(pixel_t p, logic last);
        out_word_t w;
        w.red_out     = p[CH_RED];
        w.green_out   = p[CH_GREEN];
        w.blue_out    = p[CH_BLUE];
        w.last_of_run = last;
        return w;
    endfunction

    task automatic blur_step(in_word_t w);
        int     eff_width;
        pixel_t cur;
        logic   row_end;
        eff_width = int'(row_width_q);
        if (eff_width == 0) begin
            eff_width = 1;
        end
        if (eff_width > MAX_ROW_WIDTH) begin
            eff_width = MAX_ROW_WIDTH;
        end
        cur[CH_RED]   = w.red_in;
        cur[CH_GREEN] = w.green_in;
        cur[CH_BLUE]  = w.blue_in;
        row_end = (column >= eff_width - 1) || w.last_pixel;
        if (!row_end) begin
            if (column >= 2) begin
                blurred_q.push_back(to_word(mean_px(older_px, newer_px, cur, 3), 1'b1));
            end
            older_px = newer_px;
            newer_px = cur;
            column++;
        end else begin
            // flush the held pixels together with the current one
            if (column >= 2) begin
                blurred_q.push_back(to_word(mean_px(older_px, newer_px, cur, 3), 1'b0));
            end
            if (column >= 1) begin
                blurred_q.push_back(to_word(mean_px(newer_px, cur, cur, 2), 1'b0));
            end
            blurred_q.push_back(to_word(cur, 1'b1));
            older_px = '0;
            newer_px = '0;
            column   = 0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            row_width_q = ROW_WIDTH_RESET;
            older_px    = '0;
            newer_px    = '0;
            column      = 0;
            blurred_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (blurred_q.size() == 0) begin
                    $error("result word with nothing expected: %h", m_data);
                    mismatch_count++;
                end else begin
                    want = blurred_q.pop_front();
                    if (m_data.red_out !== want.red_out) begin
                        $error("red_out: expected %0d, actual %0d",
                               want.red_out, m_data.red_out);
                        mismatch_count++;
                    end
                    if (m_data.green_out !== want.green_out) begin
                        $error("green_out: expected %0d, actual %0d",
                               want.green_out, m_data.green_out);
                        mismatch_count++;
                    end
                    if (m_data.blue_out !== want.blue_out) begin
                        $error("blue_out: expected %0d, actual %0d",
                               want.blue_out, m_data.blue_out);
                        mismatch_count++;
                    end
                    if (m_data.last_of_run !== want.last_of_run) begin
                        $error("last_of_run: expected %0d, actual %0d",
                               want.last_of_run, m_data.last_of_run);
                        mismatch_count++;
                    end
                end
            end
            // a word taken on the write edge still sees the old width
            if (s_valid && s_ready) begin
                blur_step(s_data);
            end
            if (cfg_wr_en) begin
                row_width_q = cfg_wr_data;
            end
        end
        pending_count = blurred_q.size();
    end

endmodule

@@ sim/tb_horizontal_box_blur_rgb.sv @@
// Top of the horizontal box blur testbench: clock, reset, pixel stimulus,
// row width writes, random receiver stalls and the verdict.
// Depends on hbb_pkg, the block and hbb_blur_checker.
`timescale 1ns / 1ps

module tb_horizontal_box_blur_rgb;
    import hbb_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_OFF      = 250;
    localparam int RANDOM_ITEMS  = 80;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    in_word_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_word_t        m_data;
    int               mismatch_count;
    int               pending_count;
    int               hold_off_req;
    int               idle_cycles;
    int               quiet_tx;
    int               quiet_rx;
    int               sent;
    int               phase_len;
    int               i;

    horizontal_box_blur_rgb dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    hbb_blur_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data         (s_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_data         (m_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial begin
        aclk = 1'b0;
    end

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic in_word_t make_word(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                           logic last);
        in_word_t w;
        w.red_in     = r;
        w.green_in   = g;
        w.blue_in    = b;
        w.last_pixel = last;
        return w;
    endfunction

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(0, 5))
            0: begin
                return 8'd0;
            end
            1: begin
                return 8'd255;
            end
            default: begin
                return 8'($urandom_range(0, 255));
            end
        endcase
    endfunction

    // enter and leave at a falling edge; valid stays up between back-to-back words
    task automatic send_word(in_word_t w);
        int gap;
        if (quiet_tx > 0) begin
            quiet_tx--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 13);
            if ($urandom_range(0, 9) == 0) begin
                quiet_tx = $urandom_range(8, 24);
            end
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    // drop valid and wait until every expected word is out and the pipe is empty
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_width(logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        @(negedge aclk);
    endtask

    // receiver: random wait before each word, one long hold-off on request
    initial begin
        int gap;
        bit hold_off_taken;
        hold_off_taken = 1'b0;
        m_ready = 1'b0;
        @(negedge aclk);
        forever begin
            if (hold_off_req > 0 && !hold_off_taken) begin
                gap = hold_off_req;
                hold_off_taken = 1'b1;
            end else if (quiet_rx > 0) begin
                quiet_rx--;
                gap = 0;
            end else begin
                gap = $urandom_range(0, 13);
                if ($urandom_range(0, 9) == 0) begin
                    quiet_rx = $urandom_range(8, 24);
                end
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    initial begin
        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_data       = '0;
        quiet_tx     = 0;
        sent         = 0;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // reset width: image ends at columns 0, 1, 2 and 3
        send_word(make_word(8'd255, 8'd255, 8'd255, 1'b1));
        send_word(make_word(8'd0, 8'd0, 8'd0, 1'b0));
        send_word(make_word(8'd255, 8'd255, 8'd255, 1'b1));
        send_word(make_word(8'd255, 8'd0, 8'd1, 1'b0));
        send_word(make_word(8'd255, 8'd0, 8'd0, 1'b0));
        send_word(make_word(8'd254, 8'd255, 8'd0, 1'b1));
        send_word(make_word(8'd1, 8'd2, 8'd3, 1'b0));
        send_word(make_word(8'd4, 8'd5, 8'd6, 1'b0));
        send_word(make_word(8'd7, 8'd8, 8'd9, 1'b0));
        send_word(make_word(8'd10, 8'd11, 8'd12, 1'b1));
        settle();

        // zero width acts as one pixel per row
        write_width(CFG_W'(0));
        send_word(make_word(8'd128, 8'd64, 8'd32, 1'b0));
        send_word(make_word(8'd255, 8'd0, 8'd255, 1'b0));
        settle();

        // three-pixel rows: full average, two-pixel average, pass-through
        write_width(CFG_W'(3));
        send_word(make_word(8'd255, 8'd255, 8'd0, 1'b0));
        send_word(make_word(8'd255, 8'd254, 8'd0, 1'b0));
        send_word(make_word(8'd254, 8'd0, 8'd1, 1'b0));
        send_word(make_word(8'd0, 8'd255, 8'd255, 1'b0));
        send_word(make_word(8'd1, 8'd255, 8'd254, 1'b0));
        send_word(make_word(8'd2, 8'd255, 8'd0, 1'b0));
        settle();

        // oversized width clamps to the maximum
        write_width(CFG_W'(8191));
        send_word(make_word(8'd9, 8'd99, 8'd199, 1'b0));
        send_word(make_word(8'd255, 8'd255, 8'd255, 1'b0));
        send_word(make_word(8'd0, 8'd1, 8'd2, 1'b1));
        settle();

        // shrink the width mid-row: the next pixel ends the row
        write_width(CFG_W'(5));
        send_word(make_word(8'd30, 8'd60, 8'd90, 1'b0));
        send_word(make_word(8'd31, 8'd61, 8'd91, 1'b0));
        send_word(make_word(8'd32, 8'd62, 8'd92, 1'b0));
        settle();
        write_width(CFG_W'(2));
        send_word(make_word(8'd200, 8'd100, 8'd50, 1'b0));
        settle();

        // random rows at random widths; stall the receiver hard in the first phase
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: begin
                    write_width(CFG_W'(0));
                end
                1: begin
                    write_width(CFG_W'(MAX_ROW_WIDTH));
                end
                2: begin
                    write_width(CFG_W'($urandom_range(MAX_ROW_WIDTH + 1, 8191)));
                end
                3: begin
                    write_width(CFG_W'(1));
                end
                default: begin
                    write_width(CFG_W'($urandom_range(2, 12)));
                end
            endcase
            if (sent == 0) begin
                hold_off_req = HOLD_OFF;
            end
            phase_len = $urandom_range(8, 24);
            for (i = 0; i < phase_len; i++) begin
                send_word(make_word(rand_chan(), rand_chan(), rand_chan(),
                                    $urandom_range(0, 11) == 0));
                sent++;
            end
            settle();
        end

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
